// ----- src/bqc_pkg.sv -----
package bqc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 24;
	localparam int COEF_FRAC  = 22;
	localparam int STATE_FRAC = 8;
	localparam int STATE_W    = SAMPLE_W + STATE_FRAC;
	localparam int PROD_W     = COEF_W + STATE_W;
	// five products, the middle one doubled, plus headroom
	localparam int ACC_W      = PROD_W + 4;
	localparam int REG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_LP_B0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LP_A1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LP_A2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HP_B0 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HP_A1 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HP_A2 = 3'd5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [STATE_W-1:0]  state_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	localparam coef_t RST_LP_B0 = 24'sd60398;
	localparam coef_t RST_LP_A1 = -24'sd6849298;
	localparam coef_t RST_LP_A2 = 24'sd2896586;
	localparam coef_t RST_HP_B0 = 24'sd4142714;
	localparam coef_t RST_HP_A1 = -24'sd8285009;
	localparam coef_t RST_HP_A2 = 24'sd4091963;

	localparam acc_t ACC_HALF   = acc_t'(2 ** (COEF_FRAC - 1));
	localparam acc_t ACC_ST_MAX = acc_t'(2 ** (STATE_W - 1) - 1);
	localparam acc_t ACC_ST_MIN = ~ACC_ST_MAX;

	localparam logic signed [STATE_W:0] OUT_HALF   = (STATE_W + 1)'(2 ** (STATE_FRAC - 1));
	localparam logic signed [STATE_W:0] OUT_SA_MAX = (STATE_W + 1)'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [STATE_W:0] OUT_SA_MIN = ~OUT_SA_MAX;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_ADD2,
		OP_SUB,
		OP_SUB2
	} mac_op_t;

	typedef struct packed {
		logic    issue;
		logic    first;
		mac_op_t op;
	} mac_ctl_t;

	typedef struct packed {
		coef_t lp_b0;
		coef_t lp_a1;
		coef_t lp_a2;
		coef_t hp_b0;
		coef_t hp_a1;
		coef_t hp_a2;
	} coef_set_t;

	typedef struct packed {
		state_t value;
		logic   hit;
	} state_res_t;

	typedef struct packed {
		sample_t value;
		logic    hit;
	} sample_res_t;

	function automatic state_t scale_sample(sample_t x);
		state_t s;
		s = state_t'(x) <<< STATE_FRAC;
		return s;
	endfunction

	// floor shift of the section sum, then clamp to the state width
	function automatic state_res_t round_state(acc_t a);
		acc_t       s;
		state_res_t r;
		s = a >>> COEF_FRAC;
		if (s > ACC_ST_MAX) begin
			r.value = ACC_ST_MAX[STATE_W-1:0];
			r.hit   = 1'b1;
		end else if (s < ACC_ST_MIN) begin
			r.value = ACC_ST_MIN[STATE_W-1:0];
			r.hit   = 1'b1;
		end else begin
			r.value = s[STATE_W-1:0];
			r.hit   = 1'b0;
		end
		return r;
	endfunction

	// round half up from state format to a sample, then clamp
	function automatic sample_res_t to_sample(state_t s);
		logic signed [STATE_W:0] t;
		sample_res_t             r;
		t = ((STATE_W + 1)'(s) + OUT_HALF) >>> STATE_FRAC;
		if (t > OUT_SA_MAX) begin
			r.value = OUT_SA_MAX[SAMPLE_W-1:0];
			r.hit   = 1'b1;
		end else if (t < OUT_SA_MIN) begin
			r.value = OUT_SA_MIN[SAMPLE_W-1:0];
			r.hit   = 1'b1;
		end else begin
			r.value = t[SAMPLE_W-1:0];
			r.hit   = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- src/bqc_if.sv -----
interface bqc_in_if;
	logic              valid;
	logic              ready;
	bqc_pkg::sample_t  sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface bqc_out_if;
	logic              valid;
	logic              ready;
	bqc_pkg::sample_t  filtered;
	bqc_pkg::sample_t  lowpass_value;
	logic              clipped;
	modport source (output valid, output filtered, output lowpass_value, output clipped,
		input ready);
	modport sink (input valid, input filtered, input lowpass_value, input clipped,
		output ready);
endinterface

interface bqc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [bqc_pkg::REG_IDX_W-1:0]      index;
	logic [bqc_pkg::COEF_W-1:0]         data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/bqc_regs.sv -----
module bqc_regs (
	input  logic                clk,
	input  logic                arst_n,
	bqc_cfg_if.sink             cfg,
	output bqc_pkg::coef_set_t  coefs
);
	import bqc_pkg::*;

	coef_set_t coefs_q;

	assign cfg.ready = 1'b1;
	assign coefs     = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.lp_b0 <= RST_LP_B0;
			coefs_q.lp_a1 <= RST_LP_A1;
			coefs_q.lp_a2 <= RST_LP_A2;
			coefs_q.hp_b0 <= RST_HP_B0;
			coefs_q.hp_a1 <= RST_HP_A1;
			coefs_q.hp_a2 <= RST_HP_A2;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LP_B0: coefs_q.lp_b0 <= coef_t'(cfg.data);
				REG_LP_A1: coefs_q.lp_a1 <= coef_t'(cfg.data);
				REG_LP_A2: coefs_q.lp_a2 <= coef_t'(cfg.data);
				REG_HP_B0: coefs_q.hp_b0 <= coef_t'(cfg.data);
				REG_HP_A1: coefs_q.hp_a1 <= coef_t'(cfg.data);
				REG_HP_A2: coefs_q.hp_a2 <= coef_t'(cfg.data);
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

endmodule

// ----- src/bqc_mac.sv -----
module bqc_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  bqc_pkg::mac_ctl_t  ctl,
	input  bqc_pkg::coef_t     coef,
	input  bqc_pkg::state_t    data,
	output bqc_pkg::acc_t      acc
);
	import bqc_pkg::*;

	prod_t    prod_s1;
	mac_ctl_t ctl_s1;
	acc_t     acc_q;
	acc_t     ext;
	acc_t     term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * data;
	end

	always_comb begin
		ext = acc_t'(prod_s1);
		case (ctl_s1.op)
			OP_ADD:  term = ext;
			OP_ADD2: term = ext <<< 1;
			OP_SUB:  term = -ext;
			OP_SUB2: term = -(ext <<< 1);
			default: term = ext;
		endcase
	end

	// first term of a section seeds the rounding offset
	always_ff @(posedge clk) begin
		if (ctl_s1.issue) begin
			acc_q <= (ctl_s1.first ? ACC_HALF : acc_q) + term;
		end
	end

	assign acc = acc_q;

endmodule

// ----- src/biquad_lowpass_highpass_cascade.sv -----
// An accepted sample runs through the product steps, the section captures and the
// write step before its result is valid; ten products go through one shared
// 24x24 multiplier, one per cycle, and the sample port is closed while they run.
// A finished result is held in an output register, so a new sample is taken while it waits.
// Reset (arst_n low, asynchronous): history cleared to zero, coefficients to defaults.
module biquad_lowpass_highpass_cascade (
	input  logic   clk,
	input  logic   arst_n,
	bqc_in_if.sink      samples,
	bqc_out_if.source   results,
	bqc_cfg_if.sink     cfg
);
	import bqc_pkg::*;

	localparam int STEP_W = 4;

	// low-pass terms, then high-pass terms; the high-pass current input goes last
	// because it waits for the low-pass result
	localparam logic [STEP_W-1:0] STEP_LP_X0  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_LP_X1  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_LP_X2  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LP_Y1  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_LP_Y2  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_HP_X1  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_HP_X2  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_HP_Y1  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_HP_Y2  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_HP_X0  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_HP_ACC = 4'd10;
	localparam logic [STEP_W-1:0] STEP_HP_END = 4'd11;
	localparam logic [STEP_W-1:0] STEP_WRITE  = 4'd12;
	// low-pass sum is complete once its last issue passes the product and accumulator registers
	localparam logic [STEP_W-1:0] STEP_LP_END = STEP_HP_X2;

	coef_set_t         coefs;
	mac_ctl_t          mac_ctl;
	coef_t             mac_coef;
	state_t            mac_data;
	acc_t              acc;
	state_res_t        sect;
	sample_res_t       hp_smp;
	sample_res_t       lp_smp;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	sample_t           x_q;
	sample_t           xd1_q;
	sample_t           xd2_q;
	state_t            lpd1_q;
	state_t            lpd2_q;
	state_t            hpd1_q;
	state_t            hpd2_q;
	state_t            lp_q;
	state_t            hp_q;
	logic              hp_hit_q;

	logic              out_valid_q;
	sample_t           filtered_q;
	sample_t           lowpass_q;
	logic              clipped_q;

	logic              in_beat;
	logic              out_free;
	logic              write_now;

	bqc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coefs  (coefs)
	);

	bqc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (mac_coef),
		.data   (mac_data),
		.acc    (acc)
	);

	assign samples.ready = !busy_q;
	assign in_beat       = samples.valid && !busy_q;
	assign out_free      = !out_valid_q || results.ready;
	assign write_now     = busy_q && (step_q == STEP_WRITE) && out_free;

	assign sect   = round_state(acc);
	assign hp_smp = to_sample(hp_q);
	assign lp_smp = to_sample(lp_q);

	// Operand select for the shared multiplier: one product per step up to STEP_HP_X0.
	always_comb begin
		mac_ctl  = '0;
		mac_coef = coefs.lp_b0;
		mac_data = scale_sample(x_q);
		if (busy_q) begin
			case (step_q)
				STEP_LP_X0: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b1, op: OP_ADD};
					mac_coef = coefs.lp_b0;
					mac_data = scale_sample(x_q);
				end
				STEP_LP_X1: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b0, op: OP_ADD2};
					mac_coef = coefs.lp_b0;
					mac_data = scale_sample(xd1_q);
				end
				STEP_LP_X2: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b0, op: OP_ADD};
					mac_coef = coefs.lp_b0;
					mac_data = scale_sample(xd2_q);
				end
				STEP_LP_Y1: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b0, op: OP_SUB};
					mac_coef = coefs.lp_a1;
					mac_data = lpd1_q;
				end
				STEP_LP_Y2: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b0, op: OP_SUB};
					mac_coef = coefs.lp_a2;
					mac_data = lpd2_q;
				end
				STEP_HP_X1: begin
					// opens the high-pass sum; lands the same edge the low-pass sum is taken
					mac_ctl  = '{issue: 1'b1, first: 1'b1, op: OP_SUB2};
					mac_coef = coefs.hp_b0;
					mac_data = lpd1_q;
				end
				STEP_HP_X2: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b0, op: OP_ADD};
					mac_coef = coefs.hp_b0;
					mac_data = lpd2_q;
				end
				STEP_HP_Y1: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b0, op: OP_SUB};
					mac_coef = coefs.hp_a1;
					mac_data = hpd1_q;
				end
				STEP_HP_Y2: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b0, op: OP_SUB};
					mac_coef = coefs.hp_a2;
					mac_data = hpd2_q;
				end
				STEP_HP_X0: begin
					mac_ctl  = '{issue: 1'b1, first: 1'b0, op: OP_ADD};
					mac_coef = coefs.hp_b0;
					mac_data = lp_q;
				end
				default: begin
					mac_ctl = '0;
				end
			endcase
		end
	end

	// Sequencer: step through the products, capture section results, then write out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= STEP_LP_X0;
			xd1_q    <= '0;
			xd2_q    <= '0;
			lpd1_q   <= '0;
			lpd2_q   <= '0;
			hpd1_q   <= '0;
			hpd2_q   <= '0;
		end else if (!busy_q) begin
			if (in_beat) begin
				busy_q <= 1'b1;
				step_q <= STEP_LP_X0;
			end
		end else if (step_q == STEP_WRITE) begin
			// hold until the output register is free, then advance the history
			if (out_free) begin
				busy_q <= 1'b0;
				xd2_q  <= xd1_q;
				xd1_q  <= x_q;
				lpd2_q <= lpd1_q;
				lpd1_q <= lp_q;
				hpd2_q <= hpd1_q;
				hpd1_q <= hp_q;
			end
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			x_q <= samples.sample;
		end
		if (busy_q && step_q == STEP_LP_END) begin
			lp_q <= sect.value;
		end
		if (busy_q && step_q == STEP_HP_END) begin
			hp_q     <= sect.value;
			hp_hit_q <= sect.hit;
		end
	end

	// Output register: load on write, drop on a taken beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_now) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_now) begin
			filtered_q <= hp_smp.value;
			lowpass_q  <= lp_smp.value;
			clipped_q  <= hp_hit_q | hp_smp.hit;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.filtered      = filtered_q;
	assign results.lowpass_value = lowpass_q;
	assign results.clipped       = clipped_q;

	// An accepted sample starts the sequence at the first low-pass product.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (busy_q && step_q == STEP_LP_X0))
		else $error("sample beat did not start the sequence");

	// A result appears only from the write step.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q && step_q == STEP_WRITE))
		else $error("result valid without a write step");

	// The step counter never runs past the write step.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= STEP_WRITE))
		else $error("step counter out of range");

	// Leaving the busy phase always writes the output register.
	a_done_writes: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> out_valid_q)
		else $error("sequence ended without a result");

endmodule
